/* rtl/core/lrsp_pkg.sv */
// Shared types, constants and table functions of the LR shift-reduce parser core.
// Depends on nothing; every other file of the core refers to it by scoped names.
`default_nettype none

package lrsp_pkg;

    // Default number of LR states the parse stack can hold.
    localparam int STACK_DEPTH_DEF = 64;

    // Field widths of the two channels.
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Largest value the result counters can show.
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Token queue between the front and the back.
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;
    localparam int QCNT_W      = QPTR_W + 1;

    // Character codes that the classifier looks for.
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    // LR automaton states.
    typedef logic [2:0] lr_state_t;
    localparam lr_state_t LR_ST0 = 3'd0;
    localparam lr_state_t LR_ST1 = 3'd1;
    localparam lr_state_t LR_ST2 = 3'd2;
    localparam lr_state_t LR_ST3 = 3'd3;
    localparam lr_state_t LR_ST4 = 3'd4;
    localparam lr_state_t LR_NONE = 3'd0;

    // Number of states popped by each grammar rule.
    localparam logic [1:0] RULE_SUM_POPS = 2'd3;
    localparam logic [1:0] RULE_ID_POPS  = 2'd1;

    // Table columns: the three terminals and the nonterminal E.
    typedef enum logic [1:0] {
        COL_ID   = 2'd0,
        COL_PLUS = 2'd1,
        COL_END  = 2'd2,
        COL_E    = 2'd3
    } col_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_RUN      = 2'd0,
        ST_ACCEPT   = 2'd1,
        ST_SYNTAX   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Kinds of table action.
    typedef enum logic [1:0] {
        ACT_ERROR  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_ACCEPT = 2'd2,
        ACT_REDUCE = 2'd3
    } act_kind_t;

    typedef struct packed {
        act_kind_t  kind;
        lr_state_t  target;
        logic [1:0] pops;
    } action_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_LOOK = 2'd1,
        BK_GOTO = 2'd2
    } back_state_t;

    // A classified token offered by the front to the back.
    typedef struct packed {
        logic valid;
        col_t col;
    } front_tok_t;

    // Action table for E -> id + E | id.
    function automatic action_t lr_action(lr_state_t st, col_t col);
        action_t a;
        a.kind   = ACT_ERROR;
        a.target = LR_NONE;
        a.pops   = 2'd0;
        case (st)
            LR_ST0, LR_ST3:
            begin
                if (col == COL_ID)
                begin
                    a.kind   = ACT_SHIFT;
                    a.target = LR_ST2;
                end
            end
            LR_ST1:
            begin
                if (col == COL_END)
                    a.kind = ACT_ACCEPT;
            end
            LR_ST2:
            begin
                if (col == COL_PLUS)
                begin
                    a.kind   = ACT_SHIFT;
                    a.target = LR_ST3;
                end
                else if (col == COL_END)
                begin
                    a.kind = ACT_REDUCE;
                    a.pops = RULE_ID_POPS;
                end
            end
            LR_ST4:
            begin
                if (col == COL_END)
                begin
                    a.kind = ACT_REDUCE;
                    a.pops = RULE_SUM_POPS;
                end
            end
            default:
            begin
                a.kind = ACT_ERROR;
            end
        endcase
        return a;
    endfunction

    // Goto on E; LR_NONE marks an empty cell.
    function automatic lr_state_t goto_e(lr_state_t st);
        lr_state_t g;
        case (st)
            LR_ST0:  g = LR_ST1;
            LR_ST3:  g = LR_ST4;
            default: g = LR_NONE;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lrsp_char_if.sv */
// Input channel of the parser core: one character word per handshake.
// Depends on lrsp_pkg for the field width.
`default_nettype none

interface lrsp_char_if;
    logic                        valid;
    logic                        ready;
    logic [lrsp_pkg::CHAR_W-1:0] char_code;
    logic                        end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

/* rtl/core/lrsp_result_if.sv */
// Result channel of the parser core: one result word per input word.
// Depends on lrsp_pkg for the field widths.
`default_nettype none

interface lrsp_result_if;
    logic                          valid;
    logic                          ready;
    logic [lrsp_pkg::STATUS_W-1:0] status;
    logic [lrsp_pkg::COUNT_W-1:0]  reductions;
    logic                          shifted;
    logic [lrsp_pkg::COUNT_W-1:0]  stack_level;

    modport source (output valid, output status, output reductions, output shifted,
                    output stack_level, input ready);
    modport sink (input valid, input status, input reductions, input shifted,
                  input stack_level, output ready);
endinterface

`default_nettype wire

/* rtl/core/lrsp_front.sv */
// Front end of the parser core: classifies each character word into a token
// column and holds it in a two-entry queue. Depends on lrsp_pkg and lrsp_char_if.
`default_nettype none

module lrsp_front (
    input  wire                  clk,
    input  wire                  rst_n,
    lrsp_char_if.sink            chars,
    output lrsp_pkg::front_tok_t tok,
    input  wire                  pop
);

    lrsp_pkg::col_t                 q_reg [lrsp_pkg::QUEUE_DEPTH];
    logic [lrsp_pkg::QPTR_W-1:0]    wptr_reg;
    logic [lrsp_pkg::QPTR_W-1:0]    wptr_next;
    logic [lrsp_pkg::QPTR_W-1:0]    rptr_reg;
    logic [lrsp_pkg::QPTR_W-1:0]    rptr_next;
    logic [lrsp_pkg::QCNT_W-1:0]    count_reg;
    logic [lrsp_pkg::QCNT_W-1:0]    count_next;
    lrsp_pkg::col_t                 col;
    logic                           push;
    logic                           take;

    // Map the character onto a table column.
    always_comb
    begin
        if (chars.end_of_input)
            col = lrsp_pkg::COL_END;
        else if (chars.char_code inside {[lrsp_pkg::CHAR_UPPER_A:lrsp_pkg::CHAR_UPPER_Z],
                                         [lrsp_pkg::CHAR_LOWER_A:lrsp_pkg::CHAR_LOWER_Z]})
            col = lrsp_pkg::COL_ID;
        else if (chars.char_code == lrsp_pkg::CHAR_PLUS)
            col = lrsp_pkg::COL_PLUS;
        else
            col = lrsp_pkg::COL_END;
    end

    assign chars.ready = (count_reg != lrsp_pkg::QCNT_W'(lrsp_pkg::QUEUE_DEPTH));
    assign push        = chars.valid && chars.ready;
    assign take        = pop && tok.valid;

    assign tok.valid = (count_reg != '0);
    assign tok.col   = q_reg[rptr_reg];

    // Queue pointer and fill count updates.
    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = take ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !take)
            count_next = count_reg + 1'b1;
        else if (take && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= col;
    end

endmodule

`default_nettype wire

/* rtl/core/lrsp_back.sv */
// Back end of the parser core: runs the LR action table against the state stack
// and produces one result word per token. Depends on lrsp_pkg and lrsp_result_if.
`default_nettype none

module lrsp_back #(
    parameter int STACK_DEPTH = lrsp_pkg::STACK_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  lrsp_pkg::front_tok_t tok,
    output logic                 pop,
    lrsp_result_if.source        results
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    // State stack; entry 0 always holds the start state and is never stored.
    lrsp_pkg::lr_state_t stack_mem [STACK_DEPTH];
    lrsp_pkg::lr_state_t rd_reg;
    logic                bot_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    lrsp_pkg::lr_state_t mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    lrsp_pkg::back_state_t state_reg;
    lrsp_pkg::back_state_t state_next;
    lrsp_pkg::col_t        col_reg;
    lrsp_pkg::col_t        col_next;
    logic [SP_W-1:0]       sp_reg;
    logic [SP_W-1:0]       sp_next;
    lrsp_pkg::lr_state_t   top_reg;
    lrsp_pkg::lr_state_t   top_next;
    logic                  done_reg;
    logic                  done_next;
    logic [lrsp_pkg::COUNT_W-1:0] reds_reg;
    logic [lrsp_pkg::COUNT_W-1:0] reds_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    lrsp_pkg::status_t            status_reg;
    lrsp_pkg::status_t            status_next;
    logic [lrsp_pkg::COUNT_W-1:0] out_reds_reg;
    logic [lrsp_pkg::COUNT_W-1:0] out_reds_next;
    logic                         shifted_reg;
    logic                         shifted_next;
    logic [lrsp_pkg::COUNT_W-1:0] level_reg;
    logic [lrsp_pkg::COUNT_W-1:0] level_next;

    lrsp_pkg::action_t     act;
    lrsp_pkg::lr_state_t   below;
    lrsp_pkg::lr_state_t   g;
    logic                  out_free;
    logic                  finish;
    lrsp_pkg::status_t     fin_status;
    logic                  fin_shifted;
    logic [SP_W-1:0]       pops_w;
    logic [SP_W-1:0]       sp_popped;
    logic [31:0]           sp_wide;

    assign act       = lrsp_pkg::lr_action(top_reg, col_reg);
    assign below     = bot_reg ? lrsp_pkg::LR_ST0 : rd_reg;
    assign g         = lrsp_pkg::goto_e(below);
    assign out_free  = !out_valid_reg || results.ready;
    assign pops_w    = SP_W'(act.pops);
    assign sp_popped = sp_reg - pops_w;

    // Sequencer: dequeue, look up, and for a reduction read the uncovered state
    // and push its goto.
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        sp_next     = sp_reg;
        top_next    = top_reg;
        done_next   = done_reg;
        reds_next   = reds_reg;
        pop         = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = sp_reg[AW-1:0];
        mem_wdata   = act.target;
        mem_re      = 1'b0;
        mem_raddr   = sp_popped[AW-1:0] - 1'b1;
        finish      = 1'b0;
        fin_status  = lrsp_pkg::ST_RUN;
        fin_shifted = 1'b0;

        case (state_reg)
            lrsp_pkg::BK_IDLE:
            begin
                if (tok.valid)
                begin
                    pop        = 1'b1;
                    col_next   = tok.col;
                    reds_next  = '0;
                    state_next = lrsp_pkg::BK_LOOK;
                    // A finished parse restarts from the start state.
                    if (done_reg)
                    begin
                        sp_next   = SP_W'(1);
                        top_next  = lrsp_pkg::LR_ST0;
                        done_next = 1'b0;
                    end
                end
            end
            lrsp_pkg::BK_LOOK:
            begin
                case (act.kind)
                    lrsp_pkg::ACT_SHIFT:
                    begin
                        if (out_free)
                        begin
                            finish = 1'b1;
                            if (sp_reg >= SP_W'(STACK_DEPTH))
                                fin_status = lrsp_pkg::ST_OVERFLOW;
                            else
                            begin
                                mem_we      = 1'b1;
                                sp_next     = sp_reg + 1'b1;
                                top_next    = act.target;
                                fin_shifted = 1'b1;
                            end
                        end
                    end
                    lrsp_pkg::ACT_ACCEPT:
                    begin
                        if (out_free)
                        begin
                            finish     = 1'b1;
                            fin_status = lrsp_pkg::ST_ACCEPT;
                        end
                    end
                    lrsp_pkg::ACT_REDUCE:
                    begin
                        if (sp_reg <= pops_w)
                        begin
                            if (out_free)
                            begin
                                finish     = 1'b1;
                                fin_status = lrsp_pkg::ST_SYNTAX;
                            end
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            sp_next    = sp_popped;
                            state_next = lrsp_pkg::BK_GOTO;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            finish     = 1'b1;
                            fin_status = lrsp_pkg::ST_SYNTAX;
                        end
                    end
                endcase
            end
            lrsp_pkg::BK_GOTO:
            begin
                if (g == lrsp_pkg::LR_NONE)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        fin_status = lrsp_pkg::ST_SYNTAX;
                    end
                end
                else
                begin
                    // The pop leaves room, so the goto push always fits.
                    mem_we     = 1'b1;
                    mem_wdata  = g;
                    sp_next    = sp_reg + 1'b1;
                    top_next   = g;
                    state_next = lrsp_pkg::BK_LOOK;
                    if (reds_reg != lrsp_pkg::COUNT_MAX)
                        reds_next = reds_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lrsp_pkg::BK_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = lrsp_pkg::BK_IDLE;
            done_next  = (fin_status != lrsp_pkg::ST_RUN);
        end
    end

    // Result register and its valid flag.
    assign sp_wide = 32'(sp_next);

    always_comb
    begin
        status_next    = status_reg;
        out_reds_next  = out_reds_reg;
        shifted_next   = shifted_reg;
        level_next     = level_reg;
        out_valid_next = results.ready ? 1'b0 : out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            status_next    = fin_status;
            out_reds_next  = reds_reg;
            shifted_next   = fin_shifted;
            level_next     = (sp_wide > 32'(lrsp_pkg::COUNT_MAX)) ? lrsp_pkg::COUNT_MAX
                                                                  : sp_wide[lrsp_pkg::COUNT_W-1:0];
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.reductions  = out_reds_reg;
    assign results.shifted     = shifted_reg;
    assign results.stack_level = level_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrsp_pkg::BK_IDLE;
            sp_reg        <= SP_W'(1);
            top_reg       <= lrsp_pkg::LR_ST0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        reds_reg     <= reds_next;
        status_reg   <= status_next;
        out_reds_reg <= out_reds_next;
        shifted_reg  <= shifted_next;
        level_reg    <= level_next;
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
        begin
            rd_reg  <= stack_mem[mem_raddr];
            bot_reg <= (mem_raddr == '0);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lr_shift_reduce_parser_core.sv */
// Table-driven LR parser for E -> id + E | id, taking one character word and
// returning one result word (status, reductions, shifted, stack level) per item.
// The front classifies each character (letter = id, '+' = plus, anything else or
// end of input = end token) into a two-entry queue, so input words keep flowing
// while the back works. For each token the back dequeues it and looks up the
// table action; every reduction adds a pop with a read of the uncovered stack
// entry and then the goto push, so the work for an end token grows with its
// number of reductions, which is bounded by the stack depth.
// The stack is a single memory with one write and one registered read port;
// after reset it needs no clearing. After accept, a syntax error or an overflow,
// the next word starts a fresh parse from state 0. A finished result waits in an
// output register and the back stalls only when that register is still full.
// Depends on lrsp_pkg, lrsp_char_if, lrsp_result_if, lrsp_front and lrsp_back.
`default_nettype none

module lr_shift_reduce_parser_core #(
    parameter int STACK_DEPTH = lrsp_pkg::STACK_DEPTH_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    lrsp_char_if.sink     chars,
    lrsp_result_if.source results
);

    lrsp_pkg::front_tok_t tok;
    logic                 pop;

    // Character classification and token queue.
    lrsp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .tok   (tok),
        .pop   (pop)
    );

    // Table sequencer and state stack.
    lrsp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok     (tok),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

/* tb/lr_shift_reduce_parser_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the LR shift-reduce parser core on its two handshake channels.
// A tracker class predicts the result word for each accepted character word and checks them.
// Depends on lrsp_pkg, lrsp_char_if, lrsp_result_if and the core itself.

module lr_shift_reduce_parser_core_tb;
    import lrsp_pkg::*;

    localparam int STACK_DEPTH      = STACK_DEPTH_DEF;
    localparam int RANDOM_WORDS     = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 100;
    localparam int SUM_RULE_POPS    = 3;
    localparam int ID_RULE_POPS     = 1;
    localparam longint WATCHDOG_NS  = 10_000_000;

    // What the action table asks for in one step.
    typedef enum {
        MOVE_ERROR,
        MOVE_SHIFT,
        MOVE_ACCEPT,
        MOVE_REDUCE_SUM,
        MOVE_REDUCE_ID
    } parse_move_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] reductions;
        logic               shifted;
        logic [COUNT_W-1:0] stack_level;
    } parse_result_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              eoi;
    } char_word_t;

    // Tracks the parse stack and keeps the result words still to come.
    class lr_parse_tracker;
        logic [2:0]    lr_stack [STACK_DEPTH];
        int unsigned   depth_used;
        bit            finished;
        parse_result_t expected_results [$];
        int unsigned   mismatches;
        int unsigned   results_seen;

        function new();
            fresh_parse();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void fresh_parse();
            lr_stack[0] = LR_ST0;
            depth_used  = 1;
            finished    = 1'b0;
        endfunction

        function logic [2:0] top_of_stack();
            if (depth_used == 0 || depth_used > STACK_DEPTH)
                return LR_ST0;
            return lr_stack[depth_used - 1];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Runs the parser on one accepted character word and queues its result.
        function void note_word(logic [CHAR_W-1:0] code, logic eoi);
            col_t          col;
            parse_move_t   move;
            logic [2:0]    target;
            logic [2:0]    goto_state;
            int unsigned   pops;
            parse_result_t res;
            bit            stop;

            if (finished)
                fresh_parse();

            // End of input overrides whatever byte comes with it.
            if (eoi)
                col = COL_END;
            else if ((code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) ||
                     (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z))
                col = COL_ID;
            else if (code == CHAR_PLUS)
                col = COL_PLUS;
            else
                col = COL_END;

            res.status      = ST_RUN;
            res.reductions  = '0;
            res.shifted     = 1'b0;
            stop            = 1'b0;

            while (!stop)
            begin
                // Action table for E -> id + E | id.
                move   = MOVE_ERROR;
                target = LR_ST0;
                case (top_of_stack())
                    LR_ST0, LR_ST3:
                    begin
                        if (col == COL_ID)
                        begin
                            move   = MOVE_SHIFT;
                            target = LR_ST2;
                        end
                    end
                    LR_ST1:
                    begin
                        if (col == COL_END)
                            move = MOVE_ACCEPT;
                    end
                    LR_ST2:
                    begin
                        if (col == COL_PLUS)
                        begin
                            move   = MOVE_SHIFT;
                            target = LR_ST3;
                        end
                        else if (col == COL_END)
                            move = MOVE_REDUCE_ID;
                    end
                    LR_ST4:
                    begin
                        if (col == COL_END)
                            move = MOVE_REDUCE_SUM;
                    end
                    default:
                    begin
                        move = MOVE_ERROR;
                    end
                endcase

                case (move)
                    MOVE_SHIFT:
                    begin
                        // A push onto a full stack is refused and ends the parse.
                        if (depth_used >= STACK_DEPTH)
                        begin
                            res.status = ST_OVERFLOW;
                            finished   = 1'b1;
                        end
                        else
                        begin
                            lr_stack[depth_used] = target;
                            depth_used++;
                            res.shifted = 1'b1;
                        end
                        stop = 1'b1;
                    end
                    MOVE_ACCEPT:
                    begin
                        res.status = ST_ACCEPT;
                        finished   = 1'b1;
                        stop       = 1'b1;
                    end
                    MOVE_REDUCE_SUM, MOVE_REDUCE_ID:
                    begin
                        pops = (move == MOVE_REDUCE_SUM) ? SUM_RULE_POPS : ID_RULE_POPS;
                        if (depth_used <= pops)
                        begin
                            res.status = ST_SYNTAX;
                            finished   = 1'b1;
                            stop       = 1'b1;
                        end
                        else
                        begin
                            depth_used -= pops;
                            // Goto on E. State 0 is never a goto target, so it marks
                            // an empty cell.
                            case (top_of_stack())
                                LR_ST0:  goto_state = LR_ST1;
                                LR_ST3:  goto_state = LR_ST4;
                                default: goto_state = LR_ST0;
                            endcase
                            if (goto_state == LR_ST0)
                            begin
                                res.status = ST_SYNTAX;
                                finished   = 1'b1;
                                stop       = 1'b1;
                            end
                            else if (depth_used >= STACK_DEPTH)
                            begin
                                res.status = ST_OVERFLOW;
                                finished   = 1'b1;
                                stop       = 1'b1;
                            end
                            else
                            begin
                                lr_stack[depth_used] = goto_state;
                                depth_used++;
                                if (res.reductions != COUNT_MAX)
                                    res.reductions = res.reductions + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res.status = ST_SYNTAX;
                        finished   = 1'b1;
                        stop       = 1'b1;
                    end
                endcase
            end

            res.stack_level = (depth_used > COUNT_MAX) ? COUNT_MAX : COUNT_W'(depth_used);
            expected_results.insert(expected_results.size(), res);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ns: result word %0d: %s", $time, results_seen, what);
        endtask

        // Compares one result word with the oldest expectation, field by field.
        task check_result(parse_result_t got);
            parse_result_t want;

            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result word with no character word pending");
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("status expected %0d, got %0d",
                                          want.status, got.status));
            if (got.reductions != want.reductions)
                report_mismatch($sformatf("reductions expected %0d, got %0d",
                                          want.reductions, got.reductions));
            if (got.shifted != want.shifted)
                report_mismatch($sformatf("shifted expected %0d, got %0d",
                                          want.shifted, got.shifted));
            if (got.stack_level != want.stack_level)
                report_mismatch($sformatf("stack_level expected %0d, got %0d",
                                          want.stack_level, got.stack_level));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_req = 1'b0;

    lrsp_char_if   chars_if ();
    lrsp_result_if results_if ();

    lr_parse_tracker tracker;
    char_word_t      word_buf [$];
    int unsigned     words_sent   = 0;
    int unsigned     burst_left   = 0;

    lr_shift_reduce_parser_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .results(results_if)
    );

    // Clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #(WATCHDOG_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: stall phases of random length and density, plus one long hold-off.
    initial
    begin
        int unsigned phase_left;
        int unsigned stall_pct;

        phase_left       = 0;
        stall_pct        = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                results_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(5, 60);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every result word taken by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            tracker.check_result('{status_t'(results_if.status), results_if.reductions,
                                   results_if.shifted, results_if.stack_level});
    end

    function automatic void add_word(logic [CHAR_W-1:0] code, logic eoi);
        char_word_t w;

        w.code = code;
        w.eoi  = eoi;
        word_buf.insert(word_buf.size(), w);
    endfunction

    // Builds id + id + ... + id followed by an end token, letters and end chosen at random.
    function automatic void build_sum(int unsigned ids);
        logic [CHAR_W-1:0] other;

        for (int unsigned i = 0; i < ids; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                add_word(CHAR_UPPER_A + CHAR_W'($urandom_range(0, 25)), 1'b0);
            else
                add_word(CHAR_LOWER_A + CHAR_W'($urandom_range(0, 25)), 1'b0);
            if (i + 1 < ids)
                add_word(CHAR_PLUS, 1'b0);
        end
        if ($urandom_range(0, 99) < 60)
            add_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else
        begin
            do
                other = CHAR_W'($urandom_range(0, 255));
            while ((other >= CHAR_UPPER_A && other <= CHAR_UPPER_Z) ||
                   (other >= CHAR_LOWER_A && other <= CHAR_LOWER_Z) ||
                   other == CHAR_PLUS);
            add_word(other, 1'b0);
        end
    endfunction

    // Offers one word in bursts with random gaps and waits for the handshake.
    task automatic send_word(char_word_t w);
        int unsigned gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                chars_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        chars_if.valid        <= 1'b1;
        chars_if.char_code    <= w.code;
        chars_if.end_of_input <= w.eoi;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        tracker.note_word(w.code, w.eoi);
        words_sent++;
    endtask

    task automatic flush_words();
        while (word_buf.size() != 0)
            send_word(word_buf.pop_front());
    endtask

    // Stops offering words until every expected result word has arrived.
    task automatic wait_drained();
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        int unsigned random_goal;
        int unsigned kind;
        int unsigned pos;
        bit          long_done;
        bit          hold_done;
        bit          drain_done;

        long_done  = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        tracker    = new();
        chars_if.valid        = 1'b0;
        chars_if.char_code    = '0;
        chars_if.end_of_input = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty input: end token at the bottom, the letter is ignored under end of input.
        add_word(CHAR_LOWER_A, 1'b1);
        // A single id closed by end of input with a zero byte.
        add_word(CHAR_UPPER_A, 1'b0);
        add_word(8'h00, 1'b1);
        // Three terms closed by a non-ASCII byte.
        add_word(CHAR_LOWER_Z, 1'b0);
        add_word(CHAR_PLUS, 1'b0);
        add_word(CHAR_UPPER_Z, 1'b0);
        add_word(CHAR_PLUS, 1'b0);
        add_word(CHAR_LOWER_A, 1'b0);
        add_word(8'hFF, 1'b0);
        // Plus with nothing before it.
        add_word(CHAR_PLUS, 1'b0);
        // Two ids in a row ('a', 'b').
        add_word(CHAR_LOWER_A, 1'b0);
        add_word(8'h62, 1'b0);
        // Plus after plus ('q').
        add_word(8'h71, 1'b0);
        add_word(CHAR_PLUS, 1'b0);
        add_word(CHAR_PLUS, 1'b0);
        // End token right after a plus ('m', NUL byte).
        add_word(8'h6D, 1'b0);
        add_word(CHAR_PLUS, 1'b0);
        add_word(8'h00, 1'b0);
        // Bytes just outside the letter ranges are end tokens ('@', '{', '[', '`'); 'y' in between is an id.
        add_word(8'h40, 1'b0);
        add_word(8'h79, 1'b0);
        add_word(8'h7B, 1'b0);
        add_word(8'h5B, 1'b0);
        add_word(8'h60, 1'b0);
        // A '+' byte under end of input is still the end token ('B').
        add_word(8'h42, 1'b0);
        add_word(CHAR_PLUS, 1'b1);
        flush_words();

        random_goal = words_sent + RANDOM_WORDS;
        while (words_sent < random_goal)
        begin
            kind = $urandom_range(0, 99);
            if (!long_done)
            begin
                // Long enough to run the stack full.
                build_sum(34);
                long_done = 1'b1;
            end
            else if (kind < 70)
            begin
                if ($urandom_range(0, 19) == 0)
                    build_sum($urandom_range(28, 36));
                else
                    build_sum($urandom_range(1, 6));
            end
            else if (kind < 85)
            begin
                // A well-formed sum with one word corrupted, dropped or repeated.
                build_sum($urandom_range(1, 6));
                pos = $urandom_range(0, word_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        word_buf[pos] = '{code: CHAR_W'($urandom_range(0, 255)), eoi: 1'b0};
                    end
                    1:
                    begin
                        // Without its end token the parse runs on into the next sequence.
                        word_buf.delete(word_buf.size() - 1);
                    end
                    default:
                    begin
                        word_buf.insert(pos, word_buf[pos]);
                    end
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    add_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
            flush_words();

            if (!hold_done && words_sent >= 100)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && words_sent >= 300)
            begin
                wait_drained();
                drain_done = 1'b1;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lrsp_pkg.sv
rtl/core/lrsp_char_if.sv
rtl/core/lrsp_result_if.sv
rtl/core/lrsp_front.sv
rtl/core/lrsp_back.sv
rtl/core/lr_shift_reduce_parser_core.sv
tb/lr_shift_reduce_parser_core_tb.sv
